// File: src/asm_pkg.sv
package asm_pkg;

    // Default memory size in 32-bit words.
    localparam int unsigned MEM_WORDS_DEFAULT = 65536;

    // Host commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SET_PC = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EXITED = 3'd1;
    localparam logic [2:0] ST_BAD_OP = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO = 3'd3;
    localparam logic [2:0] ST_SYSCALL = 3'd4;
    localparam logic [2:0] ST_HALTED = 3'd5;

    // Opcodes.
    localparam logic [5:0] OP_LEA = 6'd0;
    localparam logic [5:0] OP_IMM = 6'd1;
    localparam logic [5:0] OP_JMP = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ = 6'd4;
    localparam logic [5:0] OP_JNZ = 6'd5;
    localparam logic [5:0] OP_ENT = 6'd6;
    localparam logic [5:0] OP_ADJ = 6'd7;
    localparam logic [5:0] OP_LEV = 6'd8;
    localparam logic [5:0] OP_LI = 6'd9;
    localparam logic [5:0] OP_LC = 6'd10;
    localparam logic [5:0] OP_SI = 6'd11;
    localparam logic [5:0] OP_SC = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR = 6'd14;
    localparam logic [5:0] OP_XOR = 6'd15;
    localparam logic [5:0] OP_AND = 6'd16;
    localparam logic [5:0] OP_EQ = 6'd17;
    localparam logic [5:0] OP_NE = 6'd18;
    localparam logic [5:0] OP_LT = 6'd19;
    localparam logic [5:0] OP_GT = 6'd20;
    localparam logic [5:0] OP_LE = 6'd21;
    localparam logic [5:0] OP_GE = 6'd22;
    localparam logic [5:0] OP_SHL = 6'd23;
    localparam logic [5:0] OP_SHR = 6'd24;
    localparam logic [5:0] OP_ADD = 6'd25;
    localparam logic [5:0] OP_SUB = 6'd26;
    localparam logic [5:0] OP_MUL = 6'd27;
    localparam logic [5:0] OP_DIV = 6'd28;
    localparam logic [5:0] OP_MOD = 6'd29;
    localparam logic [5:0] OP_SYS_FIRST = 6'd30;
    localparam logic [5:0] OP_SYS_LAST = 6'd36;
    localparam logic [5:0] OP_EXIT = 6'd37;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_OP,
        S_FETCH_ARG,
        S_EXEC,
        S_EXIT_RD,
        S_LEV_A,
        S_LEV_B,
        S_LOAD,
        S_POP,
        S_SC_WR,
        S_ALU,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [17:0]        address;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] accumulator;
        logic [17:0]        program_counter;
        logic [17:0]        stack_pointer;
        logic signed [31:0] exit_value;
    } rsp_t;

endpackage

// File: src/accumulator_stack_machine_core.sv
// Accumulator and stack virtual machine core. A request is taken when start is
// high and busy is low; its result appears on response for exactly one cycle
// with done high, and the receiver must take it then. After reset the block
// clears its word memory, one word per cycle, and holds busy meanwhile.
// A memory write, set-pc, or a step while halted goes straight to the done state.
// A step runs on one single-port memory with registered reads: it passes opcode
// fetch, operand fetch, execute and result states; loads add a load state, SI
// and EXIT a stack-read state, SC that and a write, LEV pop states and the
// ALU ops a pop and an ALU state; DIV and MOD then wait on a bit-serial divider.
// Memory size must be a power of two; addresses wrap at MEM_WORDS*4 bytes.
module accumulator_stack_machine_core #(
    parameter int unsigned MEM_WORDS = asm_pkg::MEM_WORDS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  asm_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output asm_pkg::rsp_t response
);
    localparam int unsigned WW = $clog2(MEM_WORDS);
    localparam int unsigned BW = WW + 2;

    asm_pkg::state_t state_reg;
    asm_pkg::state_t state_next;

    logic [BW-1:0] pc_reg;
    logic [BW-1:0] pc_next;
    logic [BW-1:0] sp_reg;
    logic [BW-1:0] sp_next;
    logic [BW-1:0] bp_reg;
    logic [BW-1:0] bp_next;
    logic [31:0]   ax_reg;
    logic [31:0]   ax_next;
    logic          halted_reg;
    logic          halted_next;
    logic [31:0]   steps_reg;
    logic [31:0]   steps_next;
    logic [31:0]   op_reg;
    logic [31:0]   op_next;
    logic [31:0]   opnd_reg;
    logic [31:0]   opnd_next;
    logic [31:0]   tmp_reg;
    logic [31:0]   tmp_next;
    logic [2:0]    status_reg;
    logic [2:0]    status_next;
    logic [31:0]   exit_reg;
    logic [31:0]   exit_next;

    logic          mem_we;
    logic [WW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;
    logic          clearing;

    logic [31:0]   alu_result;
    logic [31:0]   div_result;
    logic          div_done;
    logic          div_start;

    logic          accept;
    logic [BW-1:0] nx;
    logic [BW-1:0] nx2;
    logic [BW-1:0] sp_dec;
    logic [BW-1:0] opnd_words;
    logic [BW-1:0] req_addr;
    logic [5:0]    opc;
    logic          op_bad;
    logic          op_sys;
    logic          op_div;
    logic [7:0]    byte_sel;
    logic [31:0]   byte_merge;

    asm_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .clk(clk),
        .rst_n(rst_n),
        .we(mem_we),
        .addr(mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata),
        .clearing(clearing)
    );

    asm_alu u_alu (
        .clk(clk),
        .rst_n(rst_n),
        .op(opc),
        .a(tmp_reg),
        .b(ax_reg),
        .div_start(div_start),
        .result(alu_result),
        .div_result(div_result),
        .div_done(div_done)
    );

    assign busy = (state_reg != asm_pkg::S_IDLE) || clearing;
    assign accept = start && !busy;

    // Address arithmetic wraps at the memory size.
    assign nx = pc_reg + BW'(4);
    assign nx2 = nx + BW'(4);
    assign sp_dec = sp_reg - BW'(4);
    assign opnd_words = BW'({opnd_reg[29:0], 2'b00});
    assign req_addr = BW'(request.address);

    // Opcode classes; faults are decided before anything changes.
    assign opc = op_reg[5:0];
    assign op_bad = (|op_reg[31:6]) || (opc > asm_pkg::OP_EXIT);
    assign op_sys = !op_bad && (opc >= asm_pkg::OP_SYS_FIRST) && (opc <= asm_pkg::OP_SYS_LAST);
    assign op_div = !op_bad && ((opc == asm_pkg::OP_DIV) || (opc == asm_pkg::OP_MOD));

    // Word index of the second LEV pop, one word above the first.
    function automatic logic [WW-1:0] nx_sp_word(input logic [BW-1:0] sp);
        logic [BW-1:0] s;
        s = sp + BW'(4);
        return s[BW-1:2];
    endfunction

    // Byte lane select and byte insert for LC and SC.
    always_comb
    begin
        byte_merge = mem_rdata;
        case (ax_reg[1:0])
            2'd0: byte_sel = mem_rdata[7:0];
            2'd1: byte_sel = mem_rdata[15:8];
            2'd2: byte_sel = mem_rdata[23:16];
            default: byte_sel = mem_rdata[31:24];
        endcase
        case (tmp_reg[1:0])
            2'd0: byte_merge[7:0] = ax_reg[7:0];
            2'd1: byte_merge[15:8] = ax_reg[7:0];
            2'd2: byte_merge[23:16] = ax_reg[7:0];
            default: byte_merge[31:24] = ax_reg[7:0];
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == asm_pkg::CMD_STEP && !halted_reg)
                    begin
                        state_next = asm_pkg::S_FETCH_OP;
                    end
                    else
                    begin
                        state_next = asm_pkg::S_DONE;
                    end
                end
            end
            asm_pkg::S_FETCH_OP:  state_next = asm_pkg::S_FETCH_ARG;
            asm_pkg::S_FETCH_ARG: state_next = asm_pkg::S_EXEC;
            asm_pkg::S_EXEC:
            begin
                state_next = asm_pkg::S_DONE;
                if (op_bad || op_sys || (op_div && ax_reg == '0))
                begin
                    state_next = asm_pkg::S_DONE;
                end
                else
                begin
                    unique case (opc)
                        asm_pkg::OP_EXIT: state_next = asm_pkg::S_EXIT_RD;
                        asm_pkg::OP_LEV:  state_next = asm_pkg::S_LEV_A;
                        asm_pkg::OP_LI, asm_pkg::OP_LC: state_next = asm_pkg::S_LOAD;
                        asm_pkg::OP_SI, asm_pkg::OP_SC: state_next = asm_pkg::S_POP;
                        default:
                        begin
                            if (opc >= asm_pkg::OP_OR)
                            begin
                                state_next = asm_pkg::S_POP;
                            end
                        end
                    endcase
                end
            end
            asm_pkg::S_POP:
            begin
                if (opc == asm_pkg::OP_SC)
                begin
                    state_next = asm_pkg::S_SC_WR;
                end
                else if (opc == asm_pkg::OP_SI)
                begin
                    state_next = asm_pkg::S_DONE;
                end
                else
                begin
                    state_next = asm_pkg::S_ALU;
                end
            end
            asm_pkg::S_ALU:
            begin
                state_next = op_div ? asm_pkg::S_DIV : asm_pkg::S_DONE;
            end
            asm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = asm_pkg::S_DONE;
                end
            end
            asm_pkg::S_LEV_A: state_next = asm_pkg::S_LEV_B;
            asm_pkg::S_LEV_B, asm_pkg::S_LOAD, asm_pkg::S_SC_WR,
            asm_pkg::S_EXIT_RD: state_next = asm_pkg::S_DONE;
            asm_pkg::S_DONE:  state_next = asm_pkg::S_IDLE;
            default:          state_next = asm_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory port control.
    always_comb
    begin
        pc_next = pc_reg;
        sp_next = sp_reg;
        bp_next = bp_reg;
        ax_next = ax_reg;
        halted_next = halted_reg;
        steps_next = steps_reg;
        op_next = op_reg;
        opnd_next = opnd_reg;
        tmp_next = tmp_reg;
        status_next = status_reg;
        exit_next = exit_reg;
        mem_we = 1'b0;
        mem_addr = pc_reg[BW-1:2];
        mem_wdata = ax_reg;
        div_start = 1'b0;
        unique case (state_reg)
            asm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next = asm_pkg::ST_OK;
                    exit_next = '0;
                    unique case (request.command)
                        asm_pkg::CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                            mem_addr = req_addr[BW-1:2];
                            mem_wdata = request.value;
                        end
                        asm_pkg::CMD_SET_PC:
                        begin
                            pc_next = req_addr;
                            halted_next = 1'b0;
                        end
                        asm_pkg::CMD_STEP:
                        begin
                            if (halted_reg)
                            begin
                                status_next = asm_pkg::ST_HALTED;
                            end
                        end
                        default:
                        begin
                            status_next = asm_pkg::ST_OK;
                        end
                    endcase
                end
            end
            asm_pkg::S_FETCH_OP:
            begin
                op_next = mem_rdata;
                mem_addr = nx[BW-1:2];
            end
            asm_pkg::S_FETCH_ARG:
            begin
                opnd_next = mem_rdata;
            end
            asm_pkg::S_EXEC:
            begin
                if (op_bad)
                begin
                    halted_next = 1'b1;
                    status_next = asm_pkg::ST_BAD_OP;
                end
                else if (op_sys)
                begin
                    halted_next = 1'b1;
                    status_next = asm_pkg::ST_SYSCALL;
                end
                else if (op_div && ax_reg == '0)
                begin
                    halted_next = 1'b1;
                    status_next = asm_pkg::ST_DIV_ZERO;
                end
                else if (opc == asm_pkg::OP_EXIT)
                begin
                    mem_addr = sp_reg[BW-1:2];
                end
                else
                begin
                    pc_next = nx;
                    steps_next = steps_reg + 32'd1;
                    unique case (opc)
                        asm_pkg::OP_LEA:
                        begin
                            ax_next = 32'(bp_reg) + {opnd_reg[29:0], 2'b00};
                            pc_next = nx2;
                        end
                        asm_pkg::OP_IMM:
                        begin
                            ax_next = opnd_reg;
                            pc_next = nx2;
                        end
                        asm_pkg::OP_JMP: pc_next = BW'(opnd_reg);
                        asm_pkg::OP_CALL:
                        begin
                            sp_next = sp_dec;
                            mem_we = 1'b1;
                            mem_addr = sp_dec[BW-1:2];
                            mem_wdata = 32'(nx) + 32'd4;
                            pc_next = BW'(opnd_reg);
                        end
                        asm_pkg::OP_JZ:  pc_next = (ax_reg != '0) ? nx2 : BW'(opnd_reg);
                        asm_pkg::OP_JNZ: pc_next = (ax_reg != '0) ? BW'(opnd_reg) : nx2;
                        asm_pkg::OP_ENT:
                        begin
                            mem_we = 1'b1;
                            mem_addr = sp_dec[BW-1:2];
                            mem_wdata = 32'(bp_reg);
                            bp_next = sp_dec;
                            sp_next = sp_dec - opnd_words;
                            pc_next = nx2;
                        end
                        asm_pkg::OP_ADJ:
                        begin
                            sp_next = sp_reg + opnd_words;
                            pc_next = nx2;
                        end
                        asm_pkg::OP_LEV:
                        begin
                            sp_next = bp_reg;
                            mem_addr = bp_reg[BW-1:2];
                        end
                        asm_pkg::OP_LI, asm_pkg::OP_LC:
                        begin
                            mem_addr = ax_reg[BW-1:2];
                        end
                        asm_pkg::OP_PUSH:
                        begin
                            sp_next = sp_dec;
                            mem_we = 1'b1;
                            mem_addr = sp_dec[BW-1:2];
                            mem_wdata = ax_reg;
                        end
                        default:
                        begin
                            // Every remaining opcode pops one word first.
                            mem_addr = sp_reg[BW-1:2];
                            sp_next = sp_reg + BW'(4);
                        end
                    endcase
                end
            end
            asm_pkg::S_EXIT_RD:
            begin
                exit_next = mem_rdata;
                halted_next = 1'b1;
                status_next = asm_pkg::ST_EXITED;
            end
            asm_pkg::S_LEV_A:
            begin
                bp_next = BW'(mem_rdata);
                mem_addr = nx_sp_word(sp_reg);
                sp_next = sp_reg + BW'(4);
            end
            asm_pkg::S_LEV_B:
            begin
                pc_next = BW'(mem_rdata);
                sp_next = sp_reg + BW'(4);
            end
            asm_pkg::S_LOAD:
            begin
                if (opc == asm_pkg::OP_LI)
                begin
                    ax_next = mem_rdata;
                end
                else
                begin
                    ax_next = {{24{byte_sel[7]}}, byte_sel};
                end
            end
            asm_pkg::S_POP:
            begin
                tmp_next = mem_rdata;
                if (opc == asm_pkg::OP_SI)
                begin
                    mem_we = 1'b1;
                    mem_addr = mem_rdata[BW-1:2];
                    mem_wdata = ax_reg;
                end
                else if (opc == asm_pkg::OP_SC)
                begin
                    mem_addr = mem_rdata[BW-1:2];
                end
            end
            asm_pkg::S_SC_WR:
            begin
                mem_we = 1'b1;
                mem_addr = tmp_reg[BW-1:2];
                mem_wdata = byte_merge;
            end
            asm_pkg::S_ALU:
            begin
                if (op_div)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    ax_next = alu_result;
                end
            end
            asm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    ax_next = div_result;
                end
            end
            asm_pkg::S_DONE:
            begin
                mem_addr = pc_reg[BW-1:2];
            end
            default:
            begin
                mem_addr = pc_reg[BW-1:2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asm_pkg::S_IDLE;
            pc_reg <= '0;
            sp_reg <= '0;
            bp_reg <= '0;
            ax_reg <= '0;
            halted_reg <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            bp_reg <= bp_next;
            ax_reg <= ax_next;
            halted_reg <= halted_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        opnd_reg <= opnd_next;
        tmp_reg <= tmp_next;
        status_reg <= status_next;
        exit_reg <= exit_next;
    end

    // Result is shown for the single cycle of the done state.
    assign done = (state_reg == asm_pkg::S_DONE);
    assign response.status = status_reg;
    assign response.accumulator = ax_reg;
    assign response.program_counter = 18'(pc_reg);
    assign response.stack_pointer = 18'(sp_reg);
    assign response.exit_value = exit_reg;

endmodule

// File: src/asm_mem.sv
module asm_mem #(
    parameter int unsigned MEM_WORDS = asm_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [$clog2(MEM_WORDS)-1:0] addr,
    input  logic [31:0]                  wdata,
    output logic [31:0]                  rdata,
    output logic                         clearing
);
    localparam int unsigned WW = $clog2(MEM_WORDS);

    logic [31:0]   mem [MEM_WORDS];
    logic [31:0]   rdata_reg;
    logic [WW-1:0] clr_cnt_reg;
    logic [WW-1:0] clr_cnt_next;
    logic          clearing_reg;
    logic          clearing_next;

    // Clearing pass after reset, one word per cycle.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == WW'(MEM_WORDS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // Single port: one registered read per cycle, plus at most one write.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// File: src/asm_alu.sv
module asm_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [5:0]  op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        div_start,
    output logic [31:0] result,
    output logic [31:0] div_result,
    output logic        div_done
);
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] dsr_reg;
    logic [31:0] dsr_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        run_reg;
    logic        run_next;
    logic        done_reg;
    logic        done_next;
    logic        neg_q_reg;
    logic        neg_q_next;
    logic        neg_r_reg;
    logic        neg_r_next;
    logic        is_mod_reg;
    logic        is_mod_next;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [4:0]  sh;

    assign sh = b[4:0];

    // Combinational operations.
    always_comb
    begin
        case (op)
            asm_pkg::OP_OR:  result = a | b;
            asm_pkg::OP_XOR: result = a ^ b;
            asm_pkg::OP_AND: result = a & b;
            asm_pkg::OP_EQ:  result = {31'd0, a == b};
            asm_pkg::OP_NE:  result = {31'd0, a != b};
            asm_pkg::OP_LT:  result = {31'd0, $signed(a) < $signed(b)};
            asm_pkg::OP_GT:  result = {31'd0, $signed(a) > $signed(b)};
            asm_pkg::OP_LE:  result = {31'd0, $signed(a) <= $signed(b)};
            asm_pkg::OP_GE:  result = {31'd0, $signed(a) >= $signed(b)};
            asm_pkg::OP_SHL: result = a << sh;
            asm_pkg::OP_SHR: result = $unsigned($signed(a) >>> sh);
            asm_pkg::OP_ADD: result = a + b;
            asm_pkg::OP_SUB: result = a - b;
            asm_pkg::OP_MUL: result = a * b;
            default:         result = '0;
        endcase
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        is_mod_next = is_mod_reg;
        if (div_start)
        begin
            quo_next = a[31] ? (~a + 32'd1) : a;
            dsr_next = b[31] ? (~b + 32'd1) : b;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
            neg_q_next = a[31] ^ b[31];
            neg_r_next = a[31];
            is_mod_next = (op == asm_pkg::OP_MOD);
        end
        else if (run_reg)
        begin
            if (!rem_sub[32])
            begin
                rem_next = rem_sub[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        is_mod_reg <= is_mod_next;
    end

    // Signs follow truncating division: remainder takes the dividend's sign.
    assign div_result = is_mod_reg ? (neg_r_reg ? (~rem_reg + 32'd1) : rem_reg)
                                   : (neg_q_reg ? (~quo_reg + 32'd1) : quo_reg);
    assign div_done = done_reg;

endmodule

// File: src/asm_checker.sv
module asm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input asm_pkg::rsp_t response
);
    // A result is shown while the block still reports busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while not busy");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Each request yields a single-cycle result.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result held for more than one cycle");

    // After a result the block is ready again.
    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not ready after a result");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.status <= asm_pkg::ST_HALTED))
        else $error("undefined status code");

endmodule

bind accumulator_stack_machine_core asm_checker u_asm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .response(response)
);
